FILE: src/mac_address_key_table_defines.svh
// Assertion macros for the MAC address key table RTL.
`ifndef MAC_ADDRESS_KEY_TABLE_DEFINES_SVH
`define MAC_ADDRESS_KEY_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define MAKT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("makt assertion failed");
`define MAKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("makt assertion failed");
`else
`define MAKT_ASSERT_SAME(label, ante, cons)
`define MAKT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: src/makt_pkg.sv
// Types and constants of the MAC address key table.
package makt_pkg;

  localparam int MAC_BITS = 48;
  localparam int ID_BITS = 32;
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int KEY_ID_BITS_DEF = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]          action;
    logic [MAC_BITS-1:0] mac_address;
    logic [ID_BITS-1:0]  inbound_key_id;
    logic [ID_BITS-1:0]  outbound_key_id;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               hit;
    logic [ID_BITS-1:0] found_inbound_id;
    logic [ID_BITS-1:0] found_outbound_id;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

endpackage

FILE: src/mac_address_key_table.sv
// Top level of the MAC address key table: request sequencer, slot scan and result register.
//
// Each request carries an action (insert, remove, lookup) on one 48-bit MAC address
// together with the inbound and outbound key ids to store on an insert. Each request
// yields exactly one response with a status, a hit flag and the stored ids on a hit.
// Both channels use valid and stall; a transfer happens when valid is high and stall
// is low. The table is scanned one slot per cycle through a single comparator fed by
// the entry memory's registered read port; after the scan state has stepped through
// every slot, a drain state compares the last read, then the commit state registers
// the response; no new request is taken before then. The request side stalls for
// the whole scan. The response sits in an output register: a new request is accepted
// while it waits, but its own result is not committed, and the table is not changed,
// until the previous response has been taken. Reset empties the table at once by
// clearing the per-slot valid flags; the stored addresses and ids need no clearing.
`include "mac_address_key_table_defines.svh"

module mac_address_key_table #(
  parameter int TABLE_ENTRIES = makt_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_ID_BITS = makt_pkg::KEY_ID_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  makt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output makt_pkg::rsp_t rsp
);

  localparam int IdxBits = $clog2(TABLE_ENTRIES);
  localparam int StoredBits =
    (KEY_ID_BITS < makt_pkg::ID_BITS) ? KEY_ID_BITS : makt_pkg::ID_BITS;
  localparam int EntryBits = makt_pkg::MAC_BITS + 2 * StoredBits;
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(TABLE_ENTRIES - 1);

  makt_pkg::state_t state;
  makt_pkg::req_t   req_q;
  makt_pkg::rsp_t   rsp_next;

  logic [IdxBits-1:0]       scan_idx;
  logic [IdxBits-1:0]       cmp_idx;
  logic                     rd_live;
  logic [EntryBits-1:0]     rd_data;
  logic [EntryBits-1:0]     wr_data;
  logic                     found;
  logic [IdxBits-1:0]       found_idx;
  logic [StoredBits-1:0]    found_in;
  logic [StoredBits-1:0]    found_out;
  logic                     free_found;
  logic [IdxBits-1:0]       free_idx;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [TABLE_ENTRIES-1:0] valid_next;

  logic [makt_pkg::MAC_BITS-1:0] rd_mac;
  logic [StoredBits-1:0]         rd_in;
  logic [StoredBits-1:0]         rd_out;
  logic                          slot_valid;
  logic                          match;
  logic                          empty;
  logic                          commit_go;
  logic                          mem_we;

  assign req_stall = (state != makt_pkg::S_IDLE);

  assign rd_mac = rd_data[EntryBits-1 -: makt_pkg::MAC_BITS];
  assign rd_in = rd_data[2*StoredBits-1 -: StoredBits];
  assign rd_out = rd_data[StoredBits-1:0];
  assign slot_valid = valid_q[cmp_idx];
  assign match = rd_live && slot_valid && (rd_mac == req_q.mac_address);
  assign empty = rd_live && !slot_valid;

  assign commit_go = (state == makt_pkg::S_COMMIT) && (!rsp_valid || !rsp_stall);
  assign mem_we = commit_go && (req_q.action == makt_pkg::ACT_INSERT) && !found && free_found;
  assign wr_data = {req_q.mac_address, req_q.inbound_key_id[StoredBits-1:0],
                    req_q.outbound_key_id[StoredBits-1:0]};

  makt_entry_ram #(
    .DEPTH(TABLE_ENTRIES),
    .WIDTH(EntryBits)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(free_idx),
    .wdata(wr_data),
    .raddr(scan_idx),
    .rdata(rd_data)
  );

  always_comb begin
    rsp_next = '0;
    rsp_next.status = makt_pkg::ST_NOT_FOUND;
    valid_next = valid_q;
    case (req_q.action)
      makt_pkg::ACT_INSERT: begin
        if (found) begin
          rsp_next.status = makt_pkg::ST_BUSY;
        end else if (!free_found) begin
          rsp_next.status = makt_pkg::ST_FULL;
        end else begin
          rsp_next.status = makt_pkg::ST_OK;
          valid_next[free_idx] = 1'b1;
        end
      end
      makt_pkg::ACT_REMOVE: begin
        if (found) begin
          rsp_next.status = makt_pkg::ST_OK;
          valid_next[found_idx] = 1'b0;
        end
      end
      makt_pkg::ACT_LOOKUP: begin
        if (found) begin
          rsp_next.status = makt_pkg::ST_OK;
          rsp_next.hit = 1'b1;
          rsp_next.found_inbound_id = makt_pkg::ID_BITS'(found_in);
          rsp_next.found_outbound_id = makt_pkg::ID_BITS'(found_out);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= makt_pkg::S_IDLE;
      rd_live <= 1'b0;
      rsp_valid <= 1'b0;
      valid_q <= '0;
      found <= 1'b0;
      free_found <= 1'b0;
    end else begin
      rd_live <= (state == makt_pkg::S_SCAN);
      cmp_idx <= scan_idx;
      if (match && !found) begin
        found <= 1'b1;
        found_idx <= cmp_idx;
        found_in <= rd_in;
        found_out <= rd_out;
      end
      if (empty && !free_found) begin
        free_found <= 1'b1;
        free_idx <= cmp_idx;
      end
      if (rsp_valid && !rsp_stall && !commit_go) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        makt_pkg::S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            scan_idx <= '0;
            found <= 1'b0;
            free_found <= 1'b0;
            state <= makt_pkg::S_SCAN;
          end
        end
        makt_pkg::S_SCAN: begin
          if (scan_idx == LastIdx) begin
            state <= makt_pkg::S_DRAIN;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        makt_pkg::S_DRAIN: begin
          state <= makt_pkg::S_COMMIT;
        end
        makt_pkg::S_COMMIT: begin
          if (commit_go) begin
            rsp_valid <= 1'b1;
            rsp <= rsp_next;
            valid_q <= valid_next;
            state <= makt_pkg::S_IDLE;
          end
        end
        default: begin
          state <= makt_pkg::S_IDLE;
        end
      endcase
    end
  end

  `MAKT_ASSERT_SAME(a_hit_is_ok, rsp_valid && rsp.hit, rsp.status == makt_pkg::ST_OK)
  `MAKT_ASSERT_SAME(a_miss_ids_zero, rsp_valid && !rsp.hit, rsp.found_inbound_id == '0 && rsp.found_outbound_id == '0)
  `MAKT_ASSERT_NEXT(a_accept_starts_scan, req_valid && !req_stall, state == makt_pkg::S_SCAN && scan_idx == '0)
  `MAKT_ASSERT_NEXT(a_write_sets_valid, mem_we, valid_q[$past(free_idx)] && rsp_valid)

endmodule

FILE: src/makt_entry_ram.sv
// Entry memory of the MAC address key table: one write port, one registered read port.
module makt_entry_ram #(
  parameter int DEPTH = makt_pkg::TABLE_ENTRIES_DEF,
  parameter int WIDTH = makt_pkg::MAC_BITS + 2 * makt_pkg::ID_BITS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
